>>> design/fde_pkg.sv
package fde_pkg;

   localparam int DATA_W        = 64;
   localparam int COUNT_W       = 7;
   localparam int DEGREE_W      = 4;
   localparam int MAX_ORDER_DEF = 16;
   localparam int MAX_NEXT      = 64;

   localparam logic [COUNT_W-1:0] NEXT_COUNT_RST = 7'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic tok_start;
      logic load;
      logic step;
   } cell_ctrl_type;

endpackage

>>> design/fde_cell.sv
module fde_cell #(
   parameter int IDX       = 0,
   parameter int MAX_ORDER = fde_pkg::MAX_ORDER_DEF,
   parameter int USED_W    = $clog2(MAX_ORDER + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fde_pkg::cell_ctrl_type      ctrl,
   input  logic [USED_W-1:0]           used,
   input  logic [fde_pkg::DATA_W-1:0]  lower_work,
   input  logic                        tok_in,
   input  logic [fde_pkg::DATA_W-1:0]  upper_work,
   input  logic                        upper_act,
   output logic [fde_pkg::DATA_W-1:0]  work,
   output logic                        act,
   output logic                        tok_out
);

   logic [fde_pkg::DATA_W-1:0] diag_ff, diag_in;
   logic [fde_pkg::DATA_W-1:0] work_ff, work_in;
   logic                       act_ff, act_in;
   logic                       tok_ff;
   logic                       in_use, is_top, below_top;

   assign in_use    = USED_W'(IDX) < used;
   assign is_top    = USED_W'(IDX + 1) == used;
   assign below_top = USED_W'(IDX + 1) < used;

   always_comb begin
      diag_in = diag_ff;
      work_in = work_ff;
      act_in  = act_ff;
      priority if (tok_ff && in_use) begin
         // new diagonal entry, difference passed up to the next order
         diag_in = lower_work;
         work_in = lower_work - diag_ff;
      end else if (ctrl.load) begin
         work_in = diag_ff;
         act_in  = is_top;
      end else if (ctrl.step) begin
         if (below_top && upper_act) begin
            work_in = work_ff + upper_work;
         end
         act_in = act_ff | upper_act;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         tok_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      diag_ff <= diag_in;
      work_ff <= work_in;
   end

   assign work    = work_ff;
   assign act     = act_ff;
   assign tok_out = tok_ff & in_use;

endmodule

>>> design/fde_ctrl.sv
module fde_ctrl #(
   parameter int MAX_ORDER = fde_pkg::MAX_ORDER_DEF,
   parameter int USED_W    = $clog2(MAX_ORDER + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_start_req,
   output logic                            req_stall,
   input  logic                            csr_we,
   input  logic [fde_pkg::COUNT_W-1:0]     csr_next_count,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [fde_pkg::COUNT_W-1:0]     rsp_step_ahead,
   output logic [fde_pkg::DEGREE_W-1:0]    rsp_degree,
   output logic                            rsp_last,
   input  logic                            act0,
   output fde_pkg::cell_ctrl_type          ctrl,
   output logic [USED_W-1:0]               used
);

   fde_pkg::state_type            state_ff, state_in;
   logic [USED_W-1:0]             used_ff, used_in;
   logic [USED_W-1:0]             upd_ff, upd_in;
   logic [fde_pkg::COUNT_W-1:0]   step_ff, step_in;
   logic [fde_pkg::COUNT_W-1:0]   next_count_ff;
   logic [fde_pkg::COUNT_W-1:0]   count_lim;
   logic                          accept;
   logic                          xfer;

   always_comb begin
      priority if (next_count_ff == '0) begin
         count_lim = fde_pkg::COUNT_W'(1);
      end else if (next_count_ff > fde_pkg::COUNT_W'(fde_pkg::MAX_NEXT)) begin
         count_lim = fde_pkg::COUNT_W'(fde_pkg::MAX_NEXT);
      end else begin
         count_lim = next_count_ff;
      end
   end

   assign req_stall = state_ff != fde_pkg::ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == fde_pkg::ST_RUN) && act0;
   assign xfer      = rsp_valid && !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      upd_in         = upd_ff;
      step_in        = step_ff;
      ctrl.tok_start = 1'b0;
      ctrl.load      = 1'b0;
      ctrl.step      = 1'b0;
      unique case (state_ff)
         fde_pkg::ST_IDLE: begin
            if (accept) begin
               ctrl.tok_start = 1'b1;
               upd_in         = '0;
               state_in       = fde_pkg::ST_UPDATE;
               priority if (req_start_req) begin
                  used_in = USED_W'(1);
               end else if (used_ff == USED_W'(MAX_ORDER)) begin
                  used_in = used_ff;
               end else begin
                  used_in = used_ff + USED_W'(1);
               end
            end
         end
         fde_pkg::ST_UPDATE: begin
            if (upd_ff == used_ff - USED_W'(1)) begin
               state_in = fde_pkg::ST_LOAD;
            end else begin
               upd_in = upd_ff + USED_W'(1);
            end
         end
         fde_pkg::ST_LOAD: begin
            ctrl.load = 1'b1;
            step_in   = fde_pkg::COUNT_W'(1);
            state_in  = fde_pkg::ST_RUN;
         end
         fde_pkg::ST_RUN: begin
            ctrl.step = !(rsp_valid && rsp_stall);
            if (xfer) begin
               if (step_ff == count_lim) begin
                  state_in = fde_pkg::ST_IDLE;
               end else begin
                  step_in = step_ff + fde_pkg::COUNT_W'(1);
               end
            end
         end
         default: begin
            state_in = fde_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fde_pkg::ST_IDLE;
         used_ff       <= '0;
         upd_ff        <= '0;
         step_ff       <= '0;
         next_count_ff <= fde_pkg::NEXT_COUNT_RST;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         upd_ff   <= upd_in;
         step_ff  <= step_in;
         if (csr_we) begin
            next_count_ff <= csr_next_count;
         end
      end
   end

   assign used           = used_ff;
   assign rsp_step_ahead = step_ff;
   assign rsp_last       = step_ff == count_lim;
   assign rsp_degree     = fde_pkg::DEGREE_W'(used_ff - USED_W'(1));

endmodule

>>> design/finite_difference_extrapolator.sv
// finite-difference extrapolator
// req channel: one transfer carries a 64-bit sample and start_req; start_req
// begins a new sequence before the sample is taken. req_stall is high from
// the transfer until the last result of that sample has been taken.
// rsp channel: each sample gives next_count results (0 counts as 1, above
// 64 as 64), one per transfer, with step_ahead 1..count, the degree in use
// and last set on the final one.
// csr_we writes csr_next_count; write only while the block is idle.
// steps per sample with n orders in use (n = degree + 1):
//   the update wave climbs the cell row,
//   the diagonal is copied into the working registers,
//   the sum wave runs down to order 0,
//   then one result per cycle while rsp is not stalled.
// a stalled rsp freezes the whole cell row; the result stays on the port.
// reset (synchronous) empties the sequence and sets next_count to 4.
module finite_difference_extrapolator #(
   parameter int MAX_ORDER = fde_pkg::MAX_ORDER_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fde_pkg::DATA_W-1:0]   req_sample,
   input  logic                                req_start_req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fde_pkg::DATA_W-1:0]   rsp_predicted,
   output logic [fde_pkg::COUNT_W-1:0]         rsp_step_ahead,
   output logic [fde_pkg::DEGREE_W-1:0]        rsp_degree,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [fde_pkg::COUNT_W-1:0]         csr_next_count
);

   localparam int USED_W = $clog2(MAX_ORDER + 1);

   fde_pkg::cell_ctrl_type                    ctrl;
   logic [USED_W-1:0]                         used;
   logic [fde_pkg::DATA_W-1:0]                sample_ff, sample_in;
   logic [MAX_ORDER:0][fde_pkg::DATA_W-1:0]   work_w;
   logic [MAX_ORDER:0]                        act_w;
   logic [MAX_ORDER-1:0]                      tok_w;

   assign sample_in = (req_valid && !req_stall) ? req_sample : sample_ff;

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   fde_ctrl #(
      .MAX_ORDER (MAX_ORDER),
      .USED_W    (USED_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_start_req  (req_start_req),
      .req_stall      (req_stall),
      .csr_we         (csr_we),
      .csr_next_count (csr_next_count),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_step_ahead (rsp_step_ahead),
      .rsp_degree     (rsp_degree),
      .rsp_last       (rsp_last),
      .act0           (act_w[0]),
      .ctrl           (ctrl),
      .used           (used)
   );

   assign work_w[MAX_ORDER] = '0;
   assign act_w[MAX_ORDER]  = 1'b0;
   assign tok_w[0]          = ctrl.tok_start;

   for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
      logic [fde_pkg::DATA_W-1:0] lower;
      logic                       tok_out;

      if (k == 0) begin : g_first
         assign lower = sample_ff;
      end else begin : g_rest
         assign lower = work_w[k-1];
      end

      if (k < MAX_ORDER - 1) begin : g_tok
         assign tok_w[k+1] = tok_out;
      end

      fde_cell #(
         .IDX       (k),
         .MAX_ORDER (MAX_ORDER),
         .USED_W    (USED_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .used       (used),
         .lower_work (lower),
         .tok_in     (tok_w[k]),
         .upper_work (work_w[k+1]),
         .upper_act  (act_w[k+1]),
         .work       (work_w[k]),
         .act        (act_w[k]),
         .tok_out    (tok_out)
      );
   end

   assign rsp_predicted = work_w[0];

endmodule

>>> tb/tb_finite_difference_extrapolator.sv
`timescale 1ns / 100ps

module tb_finite_difference_extrapolator;

   localparam int DATA_W      = fde_pkg::DATA_W;
   localparam int COUNT_W     = fde_pkg::COUNT_W;
   localparam int DEGREE_W    = fde_pkg::DEGREE_W;
   localparam int MAX_NEXT    = fde_pkg::MAX_NEXT;
   localparam logic [COUNT_W-1:0] NEXT_COUNT_RST = fde_pkg::NEXT_COUNT_RST;

   localparam int ORDERS      = fde_pkg::MAX_ORDER_DEF;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int PHASES      = 8;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [DATA_W-1:0]   predicted;
      logic [COUNT_W-1:0]  step_ahead;
      logic [DEGREE_W-1:0] degree;
      logic                last;
   } forecast_type;

   typedef struct packed {
      logic [DATA_W-1:0]   sample;
      logic                start;
      logic                typed;
      logic [DATA_W-1:0]   value;
      logic [DEGREE_W-1:0] degree;
   } directed_row_type;

   localparam logic [DATA_W-1:0] MIN_S = 64'h8000_0000_0000_0000;
   localparam logic [DATA_W-1:0] MAX_S = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

   directed_row_type directed_rows [0:20] = '{
      '{MIN_S, 1'b0, 1'b1, MIN_S, 4'd0},
      '{MAX_S, 1'b1, 1'b1, MAX_S, 4'd0},
      '{MAX_S, 1'b0, 1'b1, MAX_S, 4'd1},
      '{MAX_S, 1'b0, 1'b1, MAX_S, 4'd2},
      '{64'd0, 1'b1, 1'b1, 64'd0, 4'd0},
      '{64'd1, 1'b0, 1'b0, 64'd0, 4'd0},
      '{64'd2, 1'b0, 1'b0, 64'd0, 4'd0},
      '{64'd3, 1'b0, 1'b0, 64'd0, 4'd0},
      '{ONES,  1'b1, 1'b1, ONES,  4'd0},
      '{MIN_S, 1'b0, 1'b0, 64'd0, 4'd0},
      '{MAX_S, 1'b0, 1'b0, 64'd0, 4'd0},
      '{64'd0, 1'b1, 1'b1, 64'd0, 4'd0},
      '{64'd1, 1'b0, 1'b0, 64'd0, 4'd0},
      '{64'd4, 1'b0, 1'b0, 64'd0, 4'd0},
      '{64'd9, 1'b0, 1'b0, 64'd0, 4'd0},
      '{64'd16, 1'b0, 1'b0, 64'd0, 4'd0},
      '{64'd5, 1'b1, 1'b1, 64'd5, 4'd0},
      '{64'd5, 1'b0, 1'b1, 64'd5, 4'd1},
      '{64'h5555_5555_5555_5555, 1'b1, 1'b1, 64'h5555_5555_5555_5555, 4'd0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'd0, 4'd0},
      '{64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 64'h0123_4567_89AB_CDEF, 4'd0}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [DATA_W-1:0]   req_sample = '0;
   logic                       req_start_req = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]   rsp_predicted;
   logic [COUNT_W-1:0]         rsp_step_ahead;
   logic [DEGREE_W-1:0]        rsp_degree;
   logic                       rsp_last;
   logic                       csr_we = 1'b0;
   logic [COUNT_W-1:0]         csr_next_count = NEXT_COUNT_RST;

   // predictor state
   logic [DATA_W-1:0]  diagonal [ORDERS];
   int                 orders_used = 0;
   logic [COUNT_W-1:0] cfg_next_count = NEXT_COUNT_RST;
   forecast_type       fresh_q [$];
   forecast_type       forecast_q [$];

   int   err_count = 0;
   int   cycle_count = 0;
   int   samples_sent = 0;
   logic quiet = 1'b0;
   logic tx_bursty = 1'b1;
   logic rx_bursty = 1'b1;
   logic long_hold = 1'b0;
   int   stall_left = 0;
   int   rx_toggle = 0;
   forecast_type got;

   finite_difference_extrapolator #(
      .MAX_ORDER(ORDERS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_start_req  (req_start_req),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_predicted  (rsp_predicted),
      .rsp_step_ahead (rsp_step_ahead),
      .rsp_degree     (rsp_degree),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_next_count (csr_next_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // update the diagonal with one sample and list the values it extrapolates
   function automatic void extend_diagonal(logic [DATA_W-1:0] s, logic st);
      logic [DATA_W-1:0] prev, cur;
      logic [DATA_W-1:0] work [ORDERS];
      int used, total;
      forecast_type r;
      fresh_q.delete();
      if (st) orders_used = 0;
      used = (orders_used + 1 > ORDERS) ? ORDERS : orders_used + 1;
      prev = s;
      for (int k = 0; k < used; k++) begin
         cur = prev;
         if (k + 1 < used) prev = cur - diagonal[k];
         diagonal[k] = cur;
      end
      orders_used = used;
      if (cfg_next_count == 0) total = 1;
      else if (cfg_next_count > MAX_NEXT) total = MAX_NEXT;
      else total = int'(cfg_next_count);
      work = diagonal;
      for (int j = 1; j <= total; j++) begin
         for (int k = used - 1; k > 0; k--) work[k-1] = work[k-1] + work[k];
         r.predicted  = work[0];
         r.step_ahead = COUNT_W'(j);
         r.degree     = DEGREE_W'(used - 1);
         r.last       = (j == total);
         fresh_q.push_back(r);
      end
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] seen, logic [DATA_W-1:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, seen, want, cycle_count);
      err_count++;
   endtask

   task automatic send_sample(logic [DATA_W-1:0] s, logic st, logic typed,
                              logic [DATA_W-1:0] value, logic [DEGREE_W-1:0] deg);
      forecast_type r;
      if (!quiet && tx_bursty && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      if ($urandom_range(0, 29) == 0) tx_bursty = !tx_bursty;
      req_valid     <= 1'b1;
      req_sample    <= s;
      req_start_req <= st;
      do @(posedge clock); while (req_stall);
      samples_sent++;
      extend_diagonal(s, st);
      foreach (fresh_q[i]) begin
         r = fresh_q[i];
         if (typed) begin
            r.predicted = value;
            r.degree    = deg;
         end
         forecast_q.push_back(r);
      end
   endtask

   task automatic write_next_count(logic [COUNT_W-1:0] v);
      req_valid <= 1'b0;
      while (forecast_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we         <= 1'b1;
      csr_next_count <= v;
      @(posedge clock);
      csr_we         <= 1'b0;
      cfg_next_count = v;
   endtask

   function automatic logic [DATA_W-1:0] pick_word(int mag);
      logic [DATA_W-1:0] w;
      case (mag)
         0: w = DATA_W'($urandom_range(0, 2000)) - 64'd1000;
         1: w = {$urandom, $urandom};
         default: begin
            case ($urandom_range(0, 4))
               0: w = MIN_S;
               1: w = MAX_S;
               2: w = ONES;
               3: w = 64'd1;
               default: w = 64'd0;
            endcase
         end
      endcase
      return w;
   endfunction

   // mostly polynomial runs with random content, some noise and broken runs
   task automatic run_phase(int n_items);
      logic [DATA_W-1:0] coef [ORDERS + 2];
      logic [DATA_W-1:0] s;
      int sent, kind, deg, len, mag, bad;
      logic first_start;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 9);
         if (kind < 8) begin
            deg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ORDERS + 1)
                                              : $urandom_range(0, 4);
            len = ($urandom_range(0, 9) < 3) ? $urandom_range(ORDERS + 1, ORDERS + 12)
                                             : $urandom_range(1, ORDERS);
            mag = $urandom_range(0, 2);
            bad = (kind == 7) ? $urandom_range(0, len - 1) : -1;
            first_start = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < ORDERS + 2; k++)
               coef[k] = (k <= deg) ? pick_word(($urandom_range(0, 3) == 0) ? 2 : mag) : '0;
            for (int i = 0; i < len && sent < n_items; i++) begin
               s = coef[0];
               if (i == bad) s = s ^ {$urandom, $urandom};
               send_sample(s, (i == 0) ? first_start : 1'b0, 1'b0, '0, '0);
               sent++;
               for (int k = 0; k < ORDERS + 1; k++) coef[k] = coef[k] + coef[k+1];
            end
         end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len && sent < n_items; i++) begin
               send_sample(pick_word($urandom_range(0, 2)), ($urandom_range(0, 7) == 0),
                           1'b0, '0, '0);
               sent++;
            end
         end
      end
   endtask

   // receiver: random stall bursts, calm stretches, and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && rx_bursty && $urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall <= long_hold && !quiet;
      end
      rx_toggle <= rx_toggle + 1;
      if (rx_toggle % 150 == 149) rx_bursty <= ($urandom_range(0, 2) != 0);
   end

   initial begin
      wait (samples_sent >= 100);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (forecast_q.size() == 0) begin
            report_mismatch("result transfer with nothing expected", rsp_predicted, '0);
         end else begin
            got = forecast_q.pop_front();
            if (rsp_predicted !== got.predicted)
               report_mismatch("predicted", rsp_predicted, got.predicted);
            if (rsp_step_ahead !== got.step_ahead)
               report_mismatch("step_ahead", DATA_W'(rsp_step_ahead), DATA_W'(got.step_ahead));
            if (rsp_degree !== got.degree)
               report_mismatch("degree", DATA_W'(rsp_degree), DATA_W'(got.degree));
            if (rsp_last !== got.last)
               report_mismatch("last", DATA_W'(rsp_last), DATA_W'(got.last));
         end
      end
   end

   initial begin
      logic [COUNT_W-1:0] phase_count [PHASES];
      int                 phase_items [PHASES];
      foreach (diagonal[k]) diagonal[k] = '0;
      phase_count = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd65, 7'd3, NEXT_COUNT_RST};
      phase_items = '{70, 40, 30, 25, 60, 20, 70, 80};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_sample(directed_rows[i].sample, directed_rows[i].start, directed_rows[i].typed,
                     directed_rows[i].value, directed_rows[i].degree);
      for (int p = 0; p < PHASES; p++) begin
         if (p == 6) phase_count[p] = COUNT_W'($urandom_range(3, 20));
         write_next_count(phase_count[p]);
         if (p == PHASES - 1) quiet = 1'b1;
         run_phase(phase_items[p]);
      end
      req_valid <= 1'b0;
      while (forecast_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
